// File: src/pwsc_pkg.sv
// ----------------------------------------------------------------------------
// pwsc_pkg: shared types and constants of the pulse-width sound command sender
// Holds the item encoding, register indexes, timer sizing and the clamp helper.
// ----------------------------------------------------------------------------
package pwsc_pkg;

	// timer sizing; a duration register wider than the timer saturates
	localparam int TIMER_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// operation codes on the input port
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SEND = 2'd1;
	localparam logic [1:0] OP_PLAY = 2'd2;

	// register indexes on the write port
	localparam logic [CFG_IDX_W-1:0] REG_START_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP       = 2'd3;

	// register values after reset
	localparam logic [CFG_W-1:0] RST_START_LOW = 16'd40000;
	localparam logic [CFG_W-1:0] RST_SHORT     = 16'd1600;
	localparam logic [CFG_W-1:0] RST_LONG      = 16'd3200;
	localparam logic [CFG_W-1:0] RST_GAP       = 16'd3200;

	// byte sent ahead of every sound index
	localparam logic [7:0] STOP_BYTE = 8'hFE;

	// command class decided by the front
	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_SEND,
		CMD_PLAY
	} cmd_t;

	// one classified tick on its way to the back
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] payload;
		logic       not_busy_level;
	} item_t;

	// map a duration register to a timer load: zero counts as one tick,
	// values beyond the timer range saturate
	function automatic logic [TIMER_BITS-1:0] clamp_dur(input logic [CFG_W-1:0] d);
		logic [CMP_W-1:0] dx;
		dx = CMP_W'(d);
		if (dx == '0)
			dx = CMP_W'(1);
		if (dx > CMP_W'(TIMER_MAX))
			dx = CMP_W'(TIMER_MAX);
		return TIMER_BITS'(dx);
	endfunction

endpackage

// File: src/pulse_width_serial_sound_command_tx.sv
// ----------------------------------------------------------------------------
// pulse_width_serial_sound_command_tx: pulse-width one-wire command sender
// Sends command and sound bytes to a player chip, one tick per transaction.
//
// Channel   Direction  Handshake            Contents
// input     in         push / full          operation, payload, not_busy_level
// result    out        empty / pop          line_level, busy_status, sending,
//                                           command_accepted
// config    in         write_enable         write_index, write_data
//
// One transaction in, one result out, one per clock in steady state while results are popped.
// The path runs from the front register into the queue and from the queue into the result register.
// Reset clears the queue and loads the duration registers with their defaults.
// A held result stalls the engine; the queue then fills and raises full.
// ----------------------------------------------------------------------------
module pulse_width_serial_sound_command_tx
	import pwsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           operation,
	input  logic [7:0]           payload,
	input  logic                 not_busy_level,
	output logic                 empty,
	input  logic                 pop,
	output logic                 line_level,
	output logic                 busy_status,
	output logic                 sending,
	output logic                 command_accepted,
	input  logic                 write_enable,
	input  logic [CFG_IDX_W-1:0] write_index,
	input  logic [CFG_W-1:0]     write_data
);

	logic  fq_push;
	item_t fq_item;
	logic  fq_full;
	logic  bq_rd;
	item_t bq_item;
	logic  bq_valid;

	// classify incoming transactions
	pwsc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.operation      (operation),
		.payload        (payload),
		.not_busy_level (not_busy_level),
		.q_push         (fq_push),
		.q_item         (fq_item),
		.q_full         (fq_full)
	);

	// buffer classified ticks
	pwsc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fq_push),
		.wr_item (fq_item),
		.q_full  (fq_full),
		.rd      (bq_rd),
		.rd_item (bq_item),
		.q_valid (bq_valid)
	);

	// run the frame engine
	pwsc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.write_enable     (write_enable),
		.write_index      (write_index),
		.write_data       (write_data),
		.q_valid          (bq_valid),
		.q_item           (bq_item),
		.q_rd             (bq_rd),
		.empty            (empty),
		.pop              (pop),
		.line_level       (line_level),
		.busy_status      (busy_status),
		.sending          (sending),
		.command_accepted (command_accepted)
	);

endmodule

// File: src/pwsc_front.sv
// ----------------------------------------------------------------------------
// pwsc_front: input stage
// Takes one tick per transaction, classifies its operation and hands it on.
// ----------------------------------------------------------------------------
module pwsc_front
	import pwsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] operation,
	input  logic [7:0] payload,
	input  logic       not_busy_level,
	output logic       q_push,
	output item_t      q_item,
	input  logic       q_full
);

	logic  valid_s1;
	item_t item_s1;
	logic  take;
	cmd_t  cmd;

	// classify the operation; unknown codes act as a plain tick
	always_comb begin
		unique case (operation)
			OP_SEND: cmd = CMD_SEND;
			OP_PLAY: cmd = CMD_PLAY;
			default: cmd = CMD_TICK;
		endcase
	end

	// stall only when the stage holds an item the queue cannot take
	assign q_push = valid_s1 && !q_full;
	assign full   = valid_s1 && q_full;
	assign take   = push && !full;
	assign q_item = item_s1;

	// hold or advance the stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.cmd            <= cmd;
			item_s1.payload        <= payload;
			item_s1.not_busy_level <= not_busy_level;
		end
	end

endmodule

// File: src/pwsc_queue.sv
// ----------------------------------------------------------------------------
// pwsc_queue: short item queue
// Decouples the front from the back so each side can stall on its own.
// ----------------------------------------------------------------------------
module pwsc_queue
	import pwsc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wr_item,
	output logic  q_full,
	input  logic  rd,
	output item_t rd_item,
	output logic  q_valid
);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign rd_item = slot_q[rd_ptr_q];
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && q_valid;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// store the incoming item
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// File: src/pwsc_back.sv
// ----------------------------------------------------------------------------
// pwsc_back: frame engine
// Runs the start, bit-cell and gap timing of each frame, tracks busy status
// and holds the result register.
// ----------------------------------------------------------------------------
module pwsc_back
	import pwsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 write_enable,
	input  logic [CFG_IDX_W-1:0] write_index,
	input  logic [CFG_W-1:0]     write_data,
	input  logic                 q_valid,
	input  item_t                q_item,
	output logic                 q_rd,
	output logic                 empty,
	input  logic                 pop,
	output logic                 line_level,
	output logic                 busy_status,
	output logic                 sending,
	output logic                 command_accepted
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_HIGH,
		PH_LOW,
		PH_GAP
	} phase_t;

	// duration registers
	logic [CFG_W-1:0] start_low_q;
	logic [CFG_W-1:0] short_q;
	logic [CFG_W-1:0] long_q;
	logic [CFG_W-1:0] gap_q;

	// frame state
	phase_t                phase_q,   phase_n;
	logic [TIMER_BITS-1:0] timer_q,   timer_n;
	logic [7:0]            shift_q,   shift_n;
	logic [2:0]            bit_q,     bit_n;
	logic [7:0]            pend_q,    pend_n;
	logic                  pend_vld_q, pend_vld_n;
	logic                  arm_q,     arm_n;
	logic                  wfs_q,     wfs_n;

	// result register
	logic out_valid_q;
	logic line_n, busy_n, sending_n, accepted_n;
	logic step;

	// run one tick whenever one is queued and the result slot frees up
	assign step  = q_valid && (!out_valid_q || pop);
	assign q_rd  = step;
	assign empty = !out_valid_q;

	// next state of one tick
	always_comb begin
		phase_n    = phase_q;
		timer_n    = timer_q;
		shift_n    = shift_q;
		bit_n      = bit_q;
		pend_n     = pend_q;
		pend_vld_n = pend_vld_q;
		arm_n      = arm_q;
		wfs_n      = wfs_q;
		accepted_n = 1'b0;
		sending_n  = 1'b0;
		line_n     = 1'b1;

		// busy status from the state ahead of this tick
		if (wfs_q && q_item.not_busy_level) begin
			busy_n = 1'b1;
		end else if (!q_item.not_busy_level) begin
			busy_n = 1'b1;
			wfs_n  = 1'b0;
		end else begin
			busy_n = 1'b0;
		end

		// take a command only while idle
		if (phase_q == PH_IDLE && q_item.cmd != CMD_TICK) begin
			accepted_n = 1'b1;
			bit_n      = '0;
			phase_n    = PH_START;
			timer_n    = clamp_dur(start_low_q);
			if (q_item.cmd == CMD_SEND) begin
				shift_n = q_item.payload;
			end else begin
				shift_n    = STOP_BYTE;
				wfs_n      = 1'b0;
				pend_n     = q_item.payload;
				pend_vld_n = 1'b1;
				arm_n      = 1'b1;
			end
		end

		// drive the line and advance the frame timer
		if (phase_n != PH_IDLE) begin
			sending_n = 1'b1;
			line_n    = !(phase_n == PH_START || phase_n == PH_LOW);
			if (timer_n != '0)
				timer_n = timer_n - 1'b1;
			if (timer_n == '0) begin
				unique case (phase_n)
					PH_START: begin
						phase_n = PH_HIGH;
						timer_n = clamp_dur(shift_n[bit_n] ? long_q : short_q);
					end
					PH_HIGH: begin
						phase_n = PH_LOW;
						timer_n = clamp_dur(shift_n[bit_n] ? short_q : long_q);
					end
					PH_LOW: begin
						if (bit_n == 3'd7) begin
							phase_n = PH_GAP;
							timer_n = clamp_dur(gap_q);
						end else begin
							bit_n   = bit_n + 1'b1;
							phase_n = PH_HIGH;
							timer_n = clamp_dur(shift_n[bit_n] ? long_q : short_q);
						end
					end
					default: begin
						if (pend_vld_n) begin
							pend_vld_n = 1'b0;
							shift_n    = pend_n;
							bit_n      = '0;
							phase_n    = PH_START;
							timer_n    = clamp_dur(start_low_q);
						end else begin
							phase_n = PH_IDLE;
							timer_n = '0;
							if (arm_n) begin
								wfs_n = 1'b1;
								arm_n = 1'b0;
							end
						end
					end
				endcase
			end
		end
	end

	// hold state, result register and duration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_low_q      <= RST_START_LOW;
			short_q          <= RST_SHORT;
			long_q           <= RST_LONG;
			gap_q            <= RST_GAP;
			phase_q          <= PH_IDLE;
			timer_q          <= '0;
			shift_q          <= '0;
			bit_q            <= '0;
			pend_q           <= '0;
			pend_vld_q       <= 1'b0;
			arm_q            <= 1'b0;
			wfs_q            <= 1'b0;
			out_valid_q      <= 1'b0;
			line_level       <= 1'b1;
			busy_status      <= 1'b0;
			sending          <= 1'b0;
			command_accepted <= 1'b0;
		end else begin
			if (write_enable) begin
				unique case (write_index)
					REG_START_LOW: start_low_q <= write_data;
					REG_SHORT:     short_q     <= write_data;
					REG_LONG:      long_q      <= write_data;
					REG_GAP:       gap_q       <= write_data;
					default:       ;
				endcase
			end
			if (step) begin
				phase_q          <= phase_n;
				timer_q          <= timer_n;
				shift_q          <= shift_n;
				bit_q            <= bit_n;
				pend_q           <= pend_n;
				pend_vld_q       <= pend_vld_n;
				arm_q            <= arm_n;
				wfs_q            <= wfs_n;
				out_valid_q      <= 1'b1;
				line_level       <= line_n;
				busy_status      <= busy_n;
				sending          <= sending_n;
				command_accepted <= accepted_n;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the pulse-width sound command sender
// Feeds one tick per transaction through the push/full side and checks every
// line sample popped from the result side against a tick-level predictor.
// It covers idle ticks on the reset durations, zero durations, a longer start
// and gap, maximum bit-half durations while quiet, refused commands, play
// sequences with the busy-pin wait, random stalls on both sides, and a
// pause that lets all results drain mid-run.
// ----------------------------------------------------------------------------
module testbench;
	import pwsc_pkg::*;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int LATENCY_PAD  = 8;
	localparam int RANDOM_TICKS = 30;

	// operation code the block treats as a plain tick
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef enum logic [2:0] {
		LINE_IDLE,
		LINE_START,
		LINE_HIGH,
		LINE_LOW,
		LINE_GAP
	} line_phase_t;

	typedef struct packed {
		line_phase_t           phase;
		logic [TIMER_BITS-1:0] timer;
		logic [7:0]            shifter;
		logic [2:0]            bit_idx;
		logic [7:0]            queued_byte;
		logic                  queued;
		logic                  arm_wait;
		logic                  awaiting_start;
		logic                  line;
	} sender_state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] pay;
		logic       pin;
		logic       hold;   // keep back until every result has come
	} tick_cmd_t;

	typedef struct packed {
		logic line;
		logic busy;
		logic sending;
		logic taken;
	} line_sample_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [1:0]           operation = OP_TICK;
	logic [7:0]           payload = 8'h00;
	logic                 not_busy_level = 1'b1;
	logic                 empty;
	logic                 pop = 1'b0;
	logic                 line_level;
	logic                 busy_status;
	logic                 sending;
	logic                 command_accepted;
	logic                 write_enable = 1'b0;
	logic [CFG_IDX_W-1:0] write_index = REG_START_LOW;
	logic [CFG_W-1:0]     write_data = '0;

	// duration registers as the predictor sees them
	logic [CFG_W-1:0] dur_reg [4];

	sender_state_t line_st;    // advanced on each accepted transaction
	sender_state_t plan_st;    // advanced as ticks are queued
	tick_cmd_t     tick_cmds [$];
	line_sample_t  line_expect [$];
	line_sample_t  pred;
	line_sample_t  want;

	logic pin_now = 1'b1;
	logic idle_on = 1'b0;
	int   send_idle = 0;
	int   take_idle = 0;
	int   errors = 0;
	int   cycles = 0;

	pulse_width_serial_sound_command_tx dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.operation        (operation),
		.payload          (payload),
		.not_busy_level   (not_busy_level),
		.empty            (empty),
		.pop              (pop),
		.line_level       (line_level),
		.busy_status      (busy_status),
		.sending          (sending),
		.command_accepted (command_accepted),
		.write_enable     (write_enable),
		.write_index      (write_index),
		.write_data       (write_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// zero counts as one tick, anything past the timer range saturates
	function automatic logic [TIMER_BITS-1:0] tick_count(input logic [CFG_W-1:0] d);
		longint unsigned v;
		v = d;
		if (v == 0)
			v = 1;
		if (v > (64'd1 << TIMER_BITS) - 1)
			v = (64'd1 << TIMER_BITS) - 1;
		return v[TIMER_BITS-1:0];
	endfunction

	function automatic sender_state_t quiet_state();
		sender_state_t s;
		s = '0;
		s.phase = LINE_IDLE;
		s.line = 1'b1;
		return s;
	endfunction

	// one tick of the sender: busy from the pin, command, then line advance
	function automatic void advance_line(input sender_state_t cur, input tick_cmd_t c,
			output sender_state_t nxt, output line_sample_t r);
		sender_state_t s;
		logic cell_bit;
		s = cur;
		r = '0;
		if (s.awaiting_start && c.pin) begin
			r.busy = 1'b1;
		end else if (!c.pin) begin
			r.busy = 1'b1;
			s.awaiting_start = 1'b0;
		end
		// take a command only while the line is quiet
		if (s.phase == LINE_IDLE && (c.op == OP_SEND || c.op == OP_PLAY)) begin
			r.taken = 1'b1;
			if (c.op == OP_SEND) begin
				s.shifter = c.pay;
			end else begin
				s.awaiting_start = 1'b0;
				s.shifter = STOP_BYTE;
				s.queued_byte = c.pay;
				s.queued = 1'b1;
				s.arm_wait = 1'b1;
			end
			s.bit_idx = 3'd0;
			s.phase = LINE_START;
			s.timer = tick_count(dur_reg[REG_START_LOW]);
		end
		if (s.phase == LINE_IDLE) begin
			s.line = 1'b1;
		end else begin
			r.sending = 1'b1;
			s.line = !(s.phase == LINE_START || s.phase == LINE_LOW);
			if (s.timer != '0)
				s.timer = s.timer - 1'b1;
			if (s.timer == '0) begin
				cell_bit = s.shifter[s.bit_idx];
				case (s.phase)
					LINE_START: begin
						s.phase = LINE_HIGH;
						s.timer = tick_count(cell_bit ? dur_reg[REG_LONG] : dur_reg[REG_SHORT]);
					end
					LINE_HIGH: begin
						s.phase = LINE_LOW;
						s.timer = tick_count(cell_bit ? dur_reg[REG_SHORT] : dur_reg[REG_LONG]);
					end
					LINE_LOW: begin
						if (s.bit_idx == 3'd7) begin
							s.phase = LINE_GAP;
							s.timer = tick_count(dur_reg[REG_GAP]);
						end else begin
							s.bit_idx = s.bit_idx + 3'd1;
							cell_bit = s.shifter[s.bit_idx];
							s.phase = LINE_HIGH;
							s.timer = tick_count(cell_bit ? dur_reg[REG_LONG] :
								dur_reg[REG_SHORT]);
						end
					end
					default: begin
						// gap over: chain the queued byte or go quiet
						if (s.queued) begin
							s.queued = 1'b0;
							s.shifter = s.queued_byte;
							s.bit_idx = 3'd0;
							s.phase = LINE_START;
							s.timer = tick_count(dur_reg[REG_START_LOW]);
						end else begin
							s.phase = LINE_IDLE;
							s.timer = '0;
							if (s.arm_wait) begin
								s.awaiting_start = 1'b1;
								s.arm_wait = 1'b0;
							end
						end
					end
				endcase
			end
		end
		r.line = s.line;
		nxt = s;
	endfunction

	// append one tick; the pin wanders in runs of random length
	task automatic queue_tick(input logic [1:0] op, input logic [7:0] pay, input logic hold);
		tick_cmd_t c;
		line_sample_t unused;
		if ($urandom_range(0, 9) == 0)
			pin_now = !pin_now;
		c.op = op;
		c.pay = pay;
		c.pin = pin_now;
		c.hold = hold;
		advance_line(plan_st, c, plan_st, unused);
		tick_cmds.push_back(c);
	endtask

	// fill ticks until the planned line is quiet; stray commands get refused
	task automatic queue_until_quiet(input logic with_cmds);
		int r;
		while (plan_st.phase != LINE_IDLE) begin
			r = $urandom_range(0, 19);
			if (with_cmds && r == 0)
				queue_tick(OP_SEND, 8'($urandom), 1'b0);
			else if (with_cmds && r == 1)
				queue_tick(OP_PLAY, 8'($urandom), 1'b0);
			else if (r == 2)
				queue_tick(OP_SPARE, 8'($urandom), 1'b0);
			else
				queue_tick(OP_TICK, 8'($urandom), 1'b0);
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (tick_cmds.size() != 0 || line_expect.size() != 0);
		repeat (LATENCY_PAD) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		write_enable <= 1'b1;
		write_index <= idx;
		write_data <= val;
		dur_reg[idx] = val;
		@(posedge clk);
		write_enable <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_W-1:0] start_low, input logic [CFG_W-1:0] short_d,
			input logic [CFG_W-1:0] long_d, input logic [CFG_W-1:0] gap_d);
		write_reg(REG_START_LOW, start_low);
		write_reg(REG_SHORT, short_d);
		write_reg(REG_LONG, long_d);
		write_reg(REG_GAP, gap_d);
		@(negedge clk);
	endtask

	// mostly commands issued while quiet, plus refused and spare ones
	task automatic run_random(input int n, input logic idling);
		int r;
		logic [1:0] op;
		idle_on = idling;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (plan_st.phase == LINE_IDLE)
				op = (r < 45) ? OP_TICK : (r < 70) ? OP_SEND : (r < 92) ? OP_PLAY : OP_SPARE;
			else
				op = (r < 85) ? OP_TICK : (r < 89) ? OP_SEND : (r < 93) ? OP_PLAY : OP_SPARE;
			queue_tick(op, 8'($urandom), i == n / 2);
		end
		queue_until_quiet(1'b1);
		wait_drained();
	endtask

	function automatic logic [CFG_W-1:0] short_dur(input int hi);
		return CFG_W'($urandom_range(0, hi));
	endfunction

	// drive: retire the accepted transaction, then offer the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				advance_line(line_st, tick_cmds[0], line_st, pred);
				line_expect.push_back(pred);
				void'(tick_cmds.pop_front());
			end
			if (send_idle != 0) begin
				send_idle--;
				push <= 1'b0;
			end else if (tick_cmds.size() == 0 ||
					(tick_cmds[0].hold && line_expect.size() != 0)) begin
				push <= 1'b0;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				send_idle = $urandom_range(0, 15);
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				operation <= tick_cmds[0].op;
				payload <= tick_cmds[0].pay;
				not_busy_level <= tick_cmds[0].pin;
			end
		end
	end

	task automatic check_field(input string name, input logic exp_v, input logic act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// check each popped sample against the oldest prediction, then stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (line_expect.size() == 0) begin
					$display("%0t: result with nothing expected, actual %b%b%b%b", $time,
						line_level, busy_status, sending, command_accepted);
					errors++;
				end else begin
					want = line_expect.pop_front();
					check_field("line_level", want.line, line_level);
					check_field("busy_status", want.busy, busy_status);
					check_field("sending", want.sending, sending);
					check_field("command_accepted", want.taken, command_accepted);
				end
			end
			if (take_idle != 0) begin
				take_idle--;
				pop <= 1'b0;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				take_idle = $urandom_range(0, 15);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL pulse_width_serial_sound_command_tx");
			$finish;
		end
	end

	initial begin
		dur_reg[REG_START_LOW] = RST_START_LOW;
		dur_reg[REG_SHORT] = RST_SHORT;
		dur_reg[REG_LONG] = RST_LONG;
		dur_reg[REG_GAP] = RST_GAP;
		line_st = quiet_state();
		plan_st = quiet_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle ticks on the reset durations
		idle_on = 1'b0;
		for (int i = 0; i < 12; i++)
			queue_tick((i % 4 == 3) ? OP_SPARE : OP_TICK, 8'($urandom), 1'b0);
		wait_drained();

		// zero durations count as one tick; field extremes, refusals, spare op
		idle_on = 1'b1;
		configure('0, '0, '0, '0);
		queue_tick(OP_SPARE, 8'hFF, 1'b0);
		queue_tick(OP_TICK, 8'hFF, 1'b0);
		queue_tick(OP_SEND, 8'h00, 1'b0);
		queue_tick(OP_SEND, 8'hFF, 1'b0);
		queue_tick(OP_PLAY, 8'h5A, 1'b0);
		queue_tick(OP_SPARE, 8'h00, 1'b0);
		queue_until_quiet(1'b0);
		queue_tick(OP_SEND, 8'hFF, 1'b0);
		queue_until_quiet(1'b0);
		queue_tick(OP_PLAY, 8'hA5, 1'b0);
		queue_until_quiet(1'b0);
		queue_tick(OP_TICK, 8'h00, 1'b0);
		queue_tick(OP_TICK, 8'h00, 1'b0);
		// play again while the busy wait may still be armed
		queue_tick(OP_PLAY, 8'h00, 1'b0);
		queue_until_quiet(1'b0);
		wait_drained();

		// longer start and gap, short bit halves
		idle_on = 1'b0;
		configure(16'd40, 16'd1, 16'd2, 16'd32);
		queue_tick(OP_SEND, 8'h96, 1'b0);
		queue_until_quiet(1'b1);
		wait_drained();

		// longest bit halves, ticks only
		configure(16'd1, '1, '1, 16'd1);
		for (int i = 0; i < 12; i++)
			queue_tick((i % 2) ? OP_SPARE : OP_TICK, 8'($urandom), 1'b0);
		wait_drained();

		configure(16'd1, 16'd1, 16'd1, 16'd1);
		run_random(RANDOM_TICKS, 1'b1);
		configure(16'd3, 16'd2, 16'd5, 16'd4);
		run_random(RANDOM_TICKS, 1'b1);
		configure(short_dur(6), short_dur(6), short_dur(6), short_dur(6));
		run_random(RANDOM_TICKS, 1'b1);
		configure(short_dur(6), short_dur(6), short_dur(6), short_dur(6));
		run_random(RANDOM_TICKS, 1'b1);
		// closing stretch at full rate
		configure(short_dur(4), short_dur(4), short_dur(4), short_dur(4));
		run_random(RANDOM_TICKS, 1'b0);

		if (errors == 0 && line_expect.size() == 0) begin
			$display("PASS pulse_width_serial_sound_command_tx");
		end else begin
			$display("FAIL pulse_width_serial_sound_command_tx");
		end
		$finish;
	end

endmodule
